FILE: rtl/core/sbm_pkg.sv
// Shared types, constants and register codes for the spectrum band mean block.
package sbm_pkg;

    // Default parameter values
    localparam int DEF_FRAME_BINS = 512;
    localparam int DEF_GROUPS     = 8;
    localparam int DEF_MAG_BITS   = 24;

    // Fixed field widths
    localparam int MAG_W       = 24;
    localparam int INDEX_W     = 3;
    localparam int KEPT_W      = 10;
    localparam int LIMIT_W     = 24;
    localparam int BAND_W      = 16;
    localparam int STEP_HZ_W   = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;

    // Register reset values
    localparam logic [LIMIT_W-1:0]   RST_OUTLIER_LIMIT = 24'd1280000;
    localparam logic [BAND_W-1:0]    RST_BAND_LOW_HZ   = 16'd64;
    localparam logic [BAND_W-1:0]    RST_BAND_HIGH_HZ  = 16'd8128;
    localparam logic [STEP_HZ_W-1:0] RST_HZ_PER_BIN    = 8'd16;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OUTLIER_LIMIT = 2'd0,
        CFG_BAND_LOW_HZ   = 2'd1,
        CFG_BAND_HIGH_HZ  = 2'd2,
        CFG_HZ_PER_BIN    = 2'd3
    } cfg_idx_t;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } sbm_state_t;

    // Live configuration
    typedef struct packed {
        logic [LIMIT_W-1:0]   outlier_limit;
        logic [BAND_W-1:0]    band_low_hz;
        logic [BAND_W-1:0]    band_high_hz;
        logic [STEP_HZ_W-1:0] hz_per_bin;
    } sbm_cfg_t;

    // Bin beat handed to the accumulator
    typedef struct packed {
        logic accept;
        logic group_end;
    } acc_ctrl_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/spectrum_band_mean.sv
// Top level: config registers, sequencer, result register of the band mean block.
//
//  Channel  Dir  Handshake              Payload
//  s_       in   s_valid / s_ready      s_magnitude, s_group_end
//  m_       out  m_valid / m_ready      m_band_mean, m_band_index, m_kept_bins, m_frame_last
//  cfg_     in   cfg_wr_en              cfg_addr, cfg_wr_data
//
//  A bin without group end is taken in ST_IDLE. A group-end bin starts the divider and
//  closes the input; when the divider is done, the result is loaded and the input reopens.
//  Bins are accepted while an earlier result waits in the result register; a new group end
//  stalls in the divider until that result has been taken.
//  Reset is synchronous on aresetn and restores the register defaults and clears all counters.
module spectrum_band_mean
    import sbm_pkg::*;
#(
    parameter int FRAME_BINS = DEF_FRAME_BINS,
    parameter int GROUPS     = DEF_GROUPS,
    parameter int MAG_BITS   = DEF_MAG_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MAG_W-1:0]      s_magnitude,
    input  logic                  s_group_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MAG_W-1:0]      m_band_mean,
    output logic [INDEX_W-1:0]    m_band_index,
    output logic [KEPT_W-1:0]     m_kept_bins,
    output logic                  m_frame_last
);

    localparam int MagW = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
    localparam int CntW = $clog2(FRAME_BINS + 1);
    localparam int SumW = MagW + CntW;
    localparam int GrpW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    sbm_cfg_t   cfg_reg, cfg_next;
    sbm_state_t state_reg, state_next;

    acc_ctrl_t        acc_ctrl;
    div_stat_t        div_stat;
    logic [SumW-1:0]  sum_total;
    logic [CntW-1:0]  cnt_total;
    logic [GrpW-1:0]  group_idx;
    logic             group_final;
    logic [MagW-1:0]  quotient;
    logic             div_start;
    logic             load_out;
    logic             s_beat;

    logic [GrpW-1:0]    tag_group_reg;
    logic               tag_final_reg;
    logic [CntW-1:0]    tag_cnt_reg;

    logic               out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]   out_mean_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [KEPT_W-1:0]  out_kept_reg;
    logic               out_last_reg;

    // Configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_OUTLIER_LIMIT: cfg_next.outlier_limit = cfg_wr_data[LIMIT_W-1:0];
                CFG_BAND_LOW_HZ:   cfg_next.band_low_hz   = cfg_wr_data[BAND_W-1:0];
                CFG_BAND_HIGH_HZ:  cfg_next.band_high_hz  = cfg_wr_data[BAND_W-1:0];
                CFG_HZ_PER_BIN:    cfg_next.hz_per_bin    = cfg_wr_data[STEP_HZ_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outlier_limit <= RST_OUTLIER_LIMIT;
            cfg_reg.band_low_hz   <= RST_BAND_LOW_HZ;
            cfg_reg.band_high_hz  <= RST_BAND_HIGH_HZ;
            cfg_reg.hz_per_bin    <= RST_HZ_PER_BIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: accept bins, run the divider on a group end, load the result
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_group_end) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done && (!out_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_beat             = s_valid && s_ready;
    assign acc_ctrl.accept    = s_beat;
    assign acc_ctrl.group_end = s_group_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    sbm_accum #(
        .FRAME_BINS (FRAME_BINS),
        .GROUPS     (GROUPS),
        .MAG_BITS   (MAG_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .ctrl        (acc_ctrl),
        .magnitude   (s_magnitude),
        .sum_total   (sum_total),
        .cnt_total   (cnt_total),
        .group_idx   (group_idx),
        .group_final (group_final)
    );

    sbm_div #(
        .QUO_W (MagW),
        .DEN_W (CntW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (sum_total),
        .denom    (cnt_total),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Group tag captured with the divider operands
    always_ff @(posedge aclk) begin
        if (div_start) begin
            tag_group_reg <= group_idx;
            tag_final_reg <= group_final;
            tag_cnt_reg   <= cnt_total;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_mean_reg  <= MAG_W'(quotient);
            out_index_reg <= INDEX_W'(tag_group_reg);
            out_kept_reg  <= KEPT_W'(tag_cnt_reg);
            out_last_reg  <= tag_final_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_band_mean  = out_mean_reg;
    assign m_band_index = out_index_reg;
    assign m_kept_bins  = out_kept_reg;
    assign m_frame_last = out_last_reg;

`ifndef ASSERT_OFF
    // a group-end beat hands off to the divider and closes the input
    a_group_end_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_group_end) |=> (state_reg == ST_DIV && !s_ready && div_stat.busy))
        else $error("group end did not start a divide");

    // no bin is taken while the divider runs
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input ready during divide");
`endif

endmodule

FILE: rtl/core/sbm_accum.sv
// Bin filter, running sum and kept count, bin and group counters.
module sbm_accum
    import sbm_pkg::*;
#(
    parameter int FRAME_BINS = DEF_FRAME_BINS,
    parameter int GROUPS     = DEF_GROUPS,
    parameter int MAG_BITS   = DEF_MAG_BITS,
    localparam int MagW  = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W,
    localparam int CntW  = $clog2(FRAME_BINS + 1),
    localparam int SumW  = MagW + CntW,
    localparam int GrpW  = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbm_cfg_t          cfg,
    input  acc_ctrl_t         ctrl,
    input  logic [MAG_W-1:0]  magnitude,
    output logic [SumW-1:0]   sum_total,
    output logic [CntW-1:0]   cnt_total,
    output logic [GrpW-1:0]   group_idx,
    output logic              group_final
);

    localparam int BinW  = $clog2(FRAME_BINS);
    localparam int FreqW = BinW + 1 + STEP_HZ_W;
    localparam int CmpW  = (FreqW > BAND_W) ? FreqW : BAND_W;

    logic [BinW-1:0]  bin_reg,   bin_next;
    logic [GrpW-1:0]  group_reg, group_next;
    logic [SumW-1:0]  sum_reg,   sum_next;
    logic [CntW-1:0]  cnt_reg,   cnt_next;

    logic [MagW-1:0]  mag_use;
    logic [BinW:0]    bin_p1;
    logic [FreqW-1:0] freq;
    logic             keep;

    // Frequency of this bin and keep test
    assign mag_use = magnitude[MagW-1:0];
    assign bin_p1  = {1'b0, bin_reg} + (BinW+1)'(1);
    assign freq    = FreqW'(bin_p1) * FreqW'(cfg.hz_per_bin);

    assign keep = (LIMIT_W'(mag_use) <= cfg.outlier_limit)
               && (CmpW'(freq) >= CmpW'(cfg.band_low_hz))
               && (CmpW'(freq) <= CmpW'(cfg.band_high_hz))
               && (cnt_reg < CntW'(FRAME_BINS));

    // Totals including the current bin
    assign sum_total   = keep ? sum_reg + SumW'(mag_use) : sum_reg;
    assign cnt_total   = keep ? cnt_reg + CntW'(1) : cnt_reg;
    assign group_idx   = group_reg;
    assign group_final = (group_reg >= GrpW'(GROUPS - 1));

    // Counter and accumulator update
    always_comb begin
        bin_next   = bin_reg;
        group_next = group_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        if (ctrl.accept) begin
            sum_next = sum_total;
            cnt_next = cnt_total;
            if (bin_reg < BinW'(FRAME_BINS - 1)) begin
                bin_next = bin_reg + BinW'(1);
            end
            if (ctrl.group_end) begin
                sum_next = '0;
                cnt_next = '0;
                if (group_final) begin
                    group_next = '0;
                    bin_next   = '0;
                end else begin
                    group_next = group_reg + GrpW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg   <= '0;
            group_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            bin_reg   <= bin_next;
            group_reg <= group_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/sbm_div.sv
// Restoring divider, one quotient bit per cycle, zero result for a zero divisor.
module sbm_div
    import sbm_pkg::*;
#(
    parameter int QUO_W = 24,
    parameter int DEN_W = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QUO_W+DEN_W-1:0] numer,
    input  logic [DEN_W-1:0]       denom,
    output div_stat_t              stat,
    output logic [QUO_W-1:0]       quotient
);

    localparam int StepW = $clog2(QUO_W);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic             zero_reg, zero_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One trial subtract
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DEN_W];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            // high part is below the divisor, so it seeds the remainder
            rem_next  = numer[QUO_W+DEN_W-1:QUO_W];
            quo_next  = numer[QUO_W-1:0];
            den_next  = denom;
            zero_next = (denom == '0);
            step_next = StepW'(QUO_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - StepW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = zero_reg ? '0 : quo_reg;

`ifndef ASSERT_OFF
    // partial remainder always stays below a nonzero divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && den_reg != '0) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // a start always launches a run
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy_reg && !done_reg))
        else $error("divider did not start");
`endif

endmodule

FILE: tb/sv/tb_spectrum_band_mean.sv
// Self-checking testbench for spectrum_band_mean: group means of magnitude bins vs. a local model.
`timescale 1ns / 1ps

module tb_spectrum_band_mean;
    import sbm_pkg::*;

    localparam int FRAME_BINS = DEF_FRAME_BINS;
    localparam int GROUPS     = DEF_GROUPS;
    // Settle time after the last result: divider pass plus margin
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [MAG_W-1:0] mag;
        logic             last;
    } bin_beat_t;

    typedef struct {
        logic [MAG_W-1:0]   mean;
        logic [INDEX_W-1:0] index;
        logic [KEPT_W-1:0]  kept;
        logic               last;
    } band_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [MAG_W-1:0]      s_magnitude = '0;
    logic                  s_group_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [MAG_W-1:0]      m_band_mean;
    logic [INDEX_W-1:0]    m_band_index;
    logic [KEPT_W-1:0]     m_kept_bins;
    logic                  m_frame_last;

    bin_beat_t    bin_feed[$];
    band_result_t pending_means[$];
    bin_beat_t    next_bin;
    bit           bin_taken = 1'b0;
    bit           steady    = 1'b0;
    int           err_count = 0;

    // Model state and its copy of the registers
    sbm_cfg_t           cur_cfg;
    logic [8:0]         acc_bin   = '0;
    logic [INDEX_W-1:0] acc_group = '0;
    logic [32:0]        acc_sum   = '0;
    logic [KEPT_W-1:0]  acc_kept  = '0;

    spectrum_band_mean dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_magnitude  (s_magnitude),
        .s_group_end  (s_group_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_band_mean  (m_band_mean),
        .m_band_index (m_band_index),
        .m_kept_bins  (m_kept_bins),
        .m_frame_last (m_frame_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Accumulate one bin; a group end yields the expected mean
    function automatic void band_mean_model(logic [MAG_W-1:0] mag, logic last);
        logic [17:0]  freq;
        logic         keep;
        band_result_t res;
        freq = (18'(acc_bin) + 18'd1) * 18'(cur_cfg.hz_per_bin);
        keep = mag <= cur_cfg.outlier_limit && freq >= 18'(cur_cfg.band_low_hz) &&
               freq <= 18'(cur_cfg.band_high_hz) && acc_kept < KEPT_W'(FRAME_BINS);
        if (keep) begin
            acc_sum  = acc_sum + 33'(mag);
            acc_kept = acc_kept + 1'b1;
        end
        // bin index saturates on overlong frames
        if (acc_bin < 9'(FRAME_BINS - 1))
            acc_bin = acc_bin + 1'b1;
        if (last) begin
            res.mean  = (acc_kept != 0) ? MAG_W'(acc_sum / 33'(acc_kept)) : '0;
            res.index = acc_group;
            res.kept  = acc_kept;
            res.last  = (acc_group == INDEX_W'(GROUPS - 1));
            pending_means.push_back(res);
            acc_sum  = '0;
            acc_kept = '0;
            if (res.last) begin
                acc_group = '0;
                acc_bin   = '0;
            end else begin
                acc_group = acc_group + 1'b1;
            end
        end
    endfunction

    // Magnitude mix: extremes, values around the outlier limit, random
    function automatic logic [MAG_W-1:0] pick_mag();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return cur_cfg.outlier_limit;
            3: return cur_cfg.outlier_limit + 1'b1;
            4: return cur_cfg.outlier_limit - 1'b1;
            5, 6: return MAG_W'($urandom_range(32'(cur_cfg.outlier_limit)));
            default: return MAG_W'($urandom);
        endcase
    endfunction

    // Input driver: new beat only when the line is free or the last beat was taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || bin_taken) begin
            if (bin_feed.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
                next_bin = bin_feed.pop_front();
                s_valid     <= 1'b1;
                s_magnitude <= next_bin.mag;
                s_group_end <= next_bin.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= 17);
    end

    // Monitor: check result beats first, then predict from accepted bin beats
    always @(posedge aclk) begin
        band_result_t want;
        bin_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                $error("result with none expected: band_mean %0d band_index %0d",
                       m_band_mean, m_band_index);
                err_count++;
            end else begin
                want = pending_means.pop_front();
                if (m_band_mean !== want.mean) begin
                    $error("band_mean: expected %0d, actual %0d", want.mean, m_band_mean);
                    err_count++;
                end
                if (m_band_index !== want.index) begin
                    $error("band_index: expected %0d, actual %0d", want.index, m_band_index);
                    err_count++;
                end
                if (m_kept_bins !== want.kept) begin
                    $error("kept_bins: expected %0d, actual %0d", want.kept, m_kept_bins);
                    err_count++;
                end
                if (m_frame_last !== want.last) begin
                    $error("frame_last: expected %0d, actual %0d", want.last, m_frame_last);
                    err_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            band_mean_model(s_magnitude, s_group_end);
    end

    task automatic push_bin(logic [MAG_W-1:0] mag, logic last);
        bin_beat_t b;
        b.mag  = mag;
        b.last = last;
        bin_feed.push_back(b);
    endtask

    // Register write, only while the block is idle
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_OUTLIER_LIMIT: cur_cfg.outlier_limit = LIMIT_W'(val);
            CFG_BAND_LOW_HZ:   cur_cfg.band_low_hz   = BAND_W'(val);
            CFG_BAND_HIGH_HZ:  cur_cfg.band_high_hz  = BAND_W'(val);
            CFG_HZ_PER_BIN:    cur_cfg.hz_per_bin    = STEP_HZ_W'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] lim, logic [15:0] lo, logic [15:0] hi,
                             logic [7:0] hz);
        write_reg(CFG_OUTLIER_LIMIT, lim);
        write_reg(CFG_BAND_LOW_HZ, 24'(lo));
        write_reg(CFG_BAND_HIGH_HZ, 24'(hi));
        write_reg(CFG_HZ_PER_BIN, 24'(hz));
    endtask

    // One well-formed frame: GROUPS groups of random length
    task automatic queue_frame(int unsigned min_len, int unsigned max_len);
        int unsigned len;
        for (int g = 0; g < GROUPS; g++) begin
            len = $urandom_range(max_len, min_len);
            for (int unsigned i = 1; i <= len; i++)
                push_bin(pick_mag(), i == len);
        end
    endtask

    // Random bins with sparse group ends; may leave a frame half done
    task automatic queue_noise(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_bin(pick_mag(), $urandom_range(7) == 0);
    endtask

    // Wait until every beat is through, then let the divider settle
    task automatic drain();
        while (bin_feed.size() != 0 || s_valid || pending_means.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        cur_cfg.outlier_limit = RST_OUTLIER_LIMIT;
        cur_cfg.band_low_hz   = RST_BAND_LOW_HZ;
        cur_cfg.band_high_hz  = RST_BAND_HIGH_HZ;
        cur_cfg.hz_per_bin    = RST_HZ_PER_BIN;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset config: empty group, outlier edge, band low edge, truncation
        push_bin(24'd0, 1'b1);
        push_bin(24'd5, 1'b0);
        push_bin(24'd5, 1'b0);
        push_bin(24'd1280000, 1'b0);
        push_bin(24'd1280001, 1'b0);
        push_bin('1, 1'b0);
        push_bin(24'd0, 1'b0);
        push_bin(24'd1, 1'b1);
        push_bin(24'd3, 1'b0);
        push_bin(24'd4, 1'b1);
        // single-bin groups up to the end of frame
        push_bin(24'h800000, 1'b1);
        push_bin(24'h000100, 1'b1);
        push_bin(24'h0AAAAA, 1'b1);
        push_bin(24'h055555, 1'b1);
        push_bin(24'd1279999, 1'b1);
        // short frame right after the frame wrap
        for (int i = 0; i < GROUPS; i++)
            push_bin(24'(i * 7), 1'b1);
        drain();

        // Full frame at reset config crosses both band edges; no idling here
        steady = 1'b1;
        queue_frame(FRAME_BINS / GROUPS, FRAME_BINS / GROUPS);
        drain();
        steady = 1'b0;
        queue_frame(1, 6);
        queue_noise(20);
        drain();

        for (int k = 0; k < 7; k++) begin
            case (k)
                0: write_all('1, 16'd0, 16'hFFFF, 8'd1);
                1: write_all('0, 16'd0, 16'd0, 8'd0);
                2: write_all(24'($urandom_range(24'hFFFFFF)), 16'hFFFF, 16'hFFFF, 8'd255);
                6: write_all(RST_OUTLIER_LIMIT, RST_BAND_LOW_HZ, RST_BAND_HIGH_HZ,
                             RST_HZ_PER_BIN);
                default: write_all(24'($urandom_range(24'hFFFFFF)),
                                   16'($urandom_range(300)),
                                   16'($urandom_range(4000)),
                                   8'($urandom_range(255, 1)));
            endcase
            if (k == 0) begin
                // Overlong first group: kept count caps, bin index saturates
                for (int i = 0; i < FRAME_BINS + 8; i++)
                    push_bin($urandom_range(1) ? '1 : pick_mag(), 1'b0);
                push_bin('1, 1'b1);
                for (int g = 1; g < GROUPS; g++)
                    push_bin(pick_mag(), 1'b1);
            end else begin
                for (int f = 0; f < 2; f++)
                    queue_frame(1, 6);
                queue_noise(12);
                queue_frame(1, 3);
            end
            drain();
        end

        if (err_count == 0)
            $display("tb_spectrum_band_mean passed");
        else
            $display("tb_spectrum_band_mean failed");
        $finish;
    end

    // Watchdog: reports failure and stops the run if the main sequence hangs
    initial begin
        #3_000_000;
        $display("tb_spectrum_band_mean failed");
        $finish;
    end

endmodule
